// File: rtl/core/ffsc_pkg.sv
// ffsc_pkg: widths, pipeline depths and shared types of the free-space cell unit
// used by ffsc_mul, ffsc_edge, the top level and the port checker
// no dependencies
package ffsc_pkg;

   // coordinate and fraction formats
   localparam int CW        = 32;              // Q16.16 coordinate
   localparam int DW        = CW + 1;          // coordinate difference
   localparam int RW        = 31;              // range register
   localparam int RRW       = 2 * RW;          // range squared
   localparam int FRAC_BITS = 16;
   localparam int FW        = FRAC_BITS + 1;   // Q1.16 fraction
   localparam logic [FW-1:0] FRAC_ONE = FW'(1) << FRAC_BITS;

   // limb multiplier
   localparam int MUL_IW  = 68;
   localparam int LIMB_W  = 23;
   localparam int LIMBS   = 3;
   localparam int MUL_XW  = LIMB_W * LIMBS;
   localparam int ROW_W   = LIMB_W * (LIMBS + 1);
   localparam int MUL_PW  = 2 * MUL_XW;
   localparam int MUL_LAT = 4;

   // datapath widths
   localparam int PW = MUL_IW;   // first-level products and their sums
   localparam int GW = PW + 2;   // squared distance minus range squared
   localparam int QW = 108;      // quadratic value along the segment
   localparam int SW = 90;       // slope along the segment

   // pipeline shape: input, differences, products, sums, start values, search, result
   localparam int SRCH_STEPS = FW;
   localparam int PIPE_DEPTH = 2 + MUL_LAT + 2 + SRCH_STEPS + 1;
   localparam int TANG_LEN   = SRCH_STEPS + 1 - MUL_LAT;

   typedef struct packed {
      logic deg;
      logic q0le;
      logic q0ge;
      logic q1le;
      logic s0le;
      logic s0ge;
      logic s0lt;
      logic s1gt;
   } flag_type;

   typedef struct packed {
      logic          empty;
      logic [FW-1:0] low;
      logic [FW-1:0] high;
   } edge_res_type;

endpackage

// File: rtl/core/ffsc_mul.sv
// ffsc_mul: four-stage signed multiplier built from 23x23 limb products
// depends on ffsc_pkg
module ffsc_mul (
   input  logic                                clock,
   input  logic                                adv,
   input  logic signed [ffsc_pkg::MUL_IW-1:0]  op_a,
   input  logic signed [ffsc_pkg::MUL_IW-1:0]  op_b,
   output logic signed [ffsc_pkg::MUL_PW-1:0]  prod
);
   import ffsc_pkg::*;

   logic              neg1_ff, neg2_ff, neg3_ff;
   logic [MUL_IW-1:0] am_ff, bm_ff, am_in, bm_in;
   logic [MUL_XW-1:0] ax, bx;
   logic [2*LIMB_W-1:0] pp_ff [LIMBS][LIMBS];
   logic [2*LIMB_W-1:0] pp_in [LIMBS][LIMBS];
   logic [ROW_W-1:0]  row_ff [LIMBS];
   logic [ROW_W-1:0]  row_in [LIMBS];
   logic [MUL_PW-1:0] mag;
   logic signed [MUL_PW-1:0] prod_ff;

   // magnitudes
   always_comb begin
      am_in = op_a[MUL_IW-1] ? MUL_IW'(~op_a + 1'b1) : MUL_IW'(op_a);
      bm_in = op_b[MUL_IW-1] ? MUL_IW'(~op_b + 1'b1) : MUL_IW'(op_b);
   end

   assign ax = MUL_XW'(am_ff);
   assign bx = MUL_XW'(bm_ff);

   // limb products
   always_comb begin
      for (int i = 0; i < LIMBS; i++) begin
         for (int j = 0; j < LIMBS; j++) begin
            pp_in[i][j] = (2*LIMB_W)'(ax[i*LIMB_W +: LIMB_W]) *
                          (2*LIMB_W)'(bx[j*LIMB_W +: LIMB_W]);
         end
      end
   end

   // row sums
   always_comb begin
      for (int i = 0; i < LIMBS; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < LIMBS; j++) begin
            row_in[i] = row_in[i] + (ROW_W'(pp_ff[i][j]) << (j*LIMB_W));
         end
      end
   end

   // final sum
   always_comb begin
      mag = '0;
      for (int i = 0; i < LIMBS; i++) begin
         mag = mag + (MUL_PW'(row_ff[i]) << (i*LIMB_W));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg1_ff <= op_a[MUL_IW-1] ^ op_b[MUL_IW-1];
         am_ff   <= am_in;
         bm_ff   <= bm_in;
         neg2_ff <= neg1_ff;
         pp_ff   <= pp_in;
         neg3_ff <= neg2_ff;
         row_ff  <= row_in;
         prod_ff <= neg3_ff ? $signed(~mag + 1'b1) : $signed(mag);
      end
   end

   assign prod = prod_ff;

endmodule

// File: rtl/core/ffsc_edge.sv
// ffsc_edge: free interval of one cell edge, products then a 17-step bit search
// depends on ffsc_pkg and ffsc_mul
module ffsc_edge (
   input  logic                               clock,
   input  logic                               adv,
   input  logic signed [ffsc_pkg::CW-1:0]     px,
   input  logic signed [ffsc_pkg::CW-1:0]     py,
   input  logic signed [ffsc_pkg::CW-1:0]     ax,
   input  logic signed [ffsc_pkg::CW-1:0]     ay,
   input  logic signed [ffsc_pkg::CW-1:0]     bx,
   input  logic signed [ffsc_pkg::CW-1:0]     by,
   input  logic        [ffsc_pkg::RRW-1:0]    rr,
   output ffsc_pkg::edge_res_type             res
);
   import ffsc_pkg::*;

   localparam int NPROD = 8;
   localparam int P_WXWX = 0;
   localparam int P_WYWY = 1;
   localparam int P_DXDX = 2;
   localparam int P_DYDY = 3;
   localparam int P_WXDX = 4;
   localparam int P_WYDY = 5;
   localparam int P_WXDY = 6;
   localparam int P_WYDX = 7;

   logic signed [DW-1:0] wx_ff, wy_ff, dx_ff, dy_ff;
   logic signed [MUL_IW-1:0] ma [NPROD];
   logic signed [MUL_IW-1:0] mb [NPROD];
   logic signed [MUL_PW-1:0] mp [NPROD];
   logic signed [PW-1:0]     pk [NPROD];
   logic signed [GW-1:0] g0_ff;
   logic signed [PW-1:0] a_ff, dot_ff, cr_ff;
   logic signed [MUL_PW-1:0] cc_p, ar_p;
   logic                 tang_ff [TANG_LEN];
   logic signed [QW-1:0] q0_c, q1_c, q0_ff, q1_ff;
   logic signed [SW-1:0] s0_c, s1_c, s0_ff, s1_ff;
   logic signed [PW-1:0] ag_ff;
   flag_type             fl;
   logic signed [QW-1:0] q1s_ff [SRCH_STEPS];
   logic signed [SW-1:0] s1s_ff [SRCH_STEPS];
   logic [FW-1:0]        k1s_ff [SRCH_STEPS];
   logic signed [QW-1:0] q2s_ff [SRCH_STEPS];
   logic signed [SW-1:0] s2s_ff [SRCH_STEPS];
   logic [FW-1:0]        k2s_ff [SRCH_STEPS];
   logic signed [PW-1:0] as_ff  [SRCH_STEPS];
   flag_type             fs_ff  [SRCH_STEPS];
   edge_res_type         res_ff, res_in;
   logic [FW-1:0]        lo1, lo2, hi2;
   flag_type             ff;
   logic                 hit;

   // offset of the segment start from the point, and segment direction
   always_ff @(posedge clock) begin
      if (adv) begin
         wx_ff <= {ax[CW-1], ax} - {px[CW-1], px};
         wy_ff <= {ay[CW-1], ay} - {py[CW-1], py};
         dx_ff <= {bx[CW-1], bx} - {ax[CW-1], ax};
         dy_ff <= {by[CW-1], by} - {ay[CW-1], ay};
      end
   end

   // first-level products
   always_comb begin
      ma[P_WXWX] = MUL_IW'(wx_ff); mb[P_WXWX] = MUL_IW'(wx_ff);
      ma[P_WYWY] = MUL_IW'(wy_ff); mb[P_WYWY] = MUL_IW'(wy_ff);
      ma[P_DXDX] = MUL_IW'(dx_ff); mb[P_DXDX] = MUL_IW'(dx_ff);
      ma[P_DYDY] = MUL_IW'(dy_ff); mb[P_DYDY] = MUL_IW'(dy_ff);
      ma[P_WXDX] = MUL_IW'(wx_ff); mb[P_WXDX] = MUL_IW'(dx_ff);
      ma[P_WYDY] = MUL_IW'(wy_ff); mb[P_WYDY] = MUL_IW'(dy_ff);
      ma[P_WXDY] = MUL_IW'(wx_ff); mb[P_WXDY] = MUL_IW'(dy_ff);
      ma[P_WYDX] = MUL_IW'(wy_ff); mb[P_WYDX] = MUL_IW'(dx_ff);
   end

   for (genvar g = 0; g < NPROD; g++) begin : g_prod
      ffsc_mul u_mul (
         .clock (clock),
         .adv   (adv),
         .op_a  (ma[g]),
         .op_b  (mb[g]),
         .prod  (mp[g])
      );
      assign pk[g] = mp[g][PW-1:0];
   end

   // squared distance less range squared, squared length, dot and cross products
   always_ff @(posedge clock) begin
      if (adv) begin
         g0_ff  <= GW'(pk[P_WXWX]) + GW'(pk[P_WYWY]) - $signed(GW'(rr));
         a_ff   <= pk[P_DXDX] + pk[P_DYDY];
         dot_ff <= pk[P_WXDX] + pk[P_WYDY];
         cr_ff  <= pk[P_WXDY] - pk[P_WYDX];
      end
   end

   // tangency test: cross squared against length squared times range squared
   ffsc_mul u_cc (
      .clock (clock),
      .adv   (adv),
      .op_a  (cr_ff),
      .op_b  (cr_ff),
      .prod  (cc_p)
   );

   ffsc_mul u_ar (
      .clock (clock),
      .adv   (adv),
      .op_a  (a_ff),
      .op_b  ($signed(MUL_IW'(rr))),
      .prod  (ar_p)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         tang_ff[0] <= (ar_p >= cc_p);
         for (int i = 1; i < TANG_LEN; i++) begin
            tang_ff[i] <= tang_ff[i-1];
         end
      end
   end

   // quadratic and slope at both segment ends
   always_comb begin
      q0_c = QW'(g0_ff) <<< (2*FRAC_BITS);
      s0_c = SW'(dot_ff) <<< FRAC_BITS;
      q1_c = q0_c + (QW'(s0_c) <<< (FRAC_BITS+1)) + (QW'(a_ff) <<< (2*FRAC_BITS));
      s1_c = s0_c + (SW'(a_ff) <<< FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q0_ff <= q0_c;
         s0_ff <= s0_c;
         q1_ff <= q1_c;
         s1_ff <= s1_c;
         ag_ff <= a_ff;
      end
   end

   always_comb begin
      fl.deg  = (ag_ff == '0);
      fl.q0le = q0_ff[QW-1] || (q0_ff == '0);
      fl.q0ge = !q0_ff[QW-1];
      fl.q1le = q1_ff[QW-1] || (q1_ff == '0);
      fl.s0le = s0_ff[SW-1] || (s0_ff == '0);
      fl.s0ge = !s0_ff[SW-1];
      fl.s0lt = s0_ff[SW-1];
      fl.s1gt = !s1_ff[SW-1] && (s1_ff != '0);
   end

   // bit search, one fraction bit per stage, most significant first;
   // search one keeps the last sample still falling and out of range,
   // search two the last sample not yet rising out of range
   for (genvar st = 0; st < SRCH_STEPS; st++) begin : g_step
      localparam int J = SRCH_STEPS - 1 - st;
      localparam logic [FW:0] STEP = (FW+1)'(1) << J;

      logic signed [QW-1:0] qa, qb, qc1, qc2;
      logic signed [SW-1:0] sa, sb, sc1, sc2;
      logic [FW-1:0]        ka, kb;
      logic [FW:0]          kc1, kc2;
      logic signed [PW-1:0] aa;
      flag_type             fa;
      logic                 take1, take2;

      if (st == 0) begin : g_first
         assign qa = q0_ff;
         assign sa = s0_ff;
         assign ka = '0;
         assign qb = q0_ff;
         assign sb = s0_ff;
         assign kb = '0;
         assign aa = ag_ff;
         assign fa = fl;
      end else begin : g_next
         assign qa = q1s_ff[st-1];
         assign sa = s1s_ff[st-1];
         assign ka = k1s_ff[st-1];
         assign qb = q2s_ff[st-1];
         assign sb = s2s_ff[st-1];
         assign kb = k2s_ff[st-1];
         assign aa = as_ff[st-1];
         assign fa = fs_ff[st-1];
      end

      always_comb begin
         qc1 = qa + (QW'(sa) <<< (J+1)) + (QW'(aa) <<< (2*J));
         sc1 = sa + (SW'(aa) <<< J);
         kc1 = {1'b0, ka} + STEP;
         qc2 = qb + (QW'(sb) <<< (J+1)) + (QW'(aa) <<< (2*J));
         sc2 = sb + (SW'(aa) <<< J);
         kc2 = {1'b0, kb} + STEP;
         take1 = (kc1 <= {1'b0, FRAC_ONE}) && !qc1[QW-1] &&
                 (sc1[SW-1] || (sc1 == '0));
         take2 = (kc2 <= {1'b0, FRAC_ONE}) && (qc2[QW-1] || sc2[SW-1]);
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q1s_ff[st] <= take1 ? qc1 : qa;
            s1s_ff[st] <= take1 ? sc1 : sa;
            k1s_ff[st] <= take1 ? kc1[FW-1:0] : ka;
            q2s_ff[st] <= take2 ? qc2 : qb;
            s2s_ff[st] <= take2 ? sc2 : sb;
            k2s_ff[st] <= take2 ? kc2[FW-1:0] : kb;
            as_ff[st]  <= aa;
            fs_ff[st]  <= fa;
         end
      end
   end

   // interval from the two searches
   always_comb begin
      ff  = fs_ff[SRCH_STEPS-1];
      lo1 = k1s_ff[SRCH_STEPS-1];
      lo2 = k2s_ff[SRCH_STEPS-1];
      hi2 = (lo2 == FRAC_ONE) ? FRAC_ONE : lo2 + 1'b1;
      hit = ff.q0le || ff.q1le || (ff.s0lt && ff.s1gt && tang_ff[TANG_LEN-1]);
      res_in = '{empty: 1'b1, low: '0, high: '0};
      if (ff.deg) begin
         // zero-length segment: whole edge or nothing
         if (ff.q0le) begin
            res_in = '{empty: 1'b0, low: '0, high: FRAC_ONE};
         end
      end else if (hit) begin
         res_in.empty = 1'b0;
         res_in.low   = (ff.q0ge && ff.s0le) ? lo1 : '0;
         res_in.high  = (ff.q0ge && ff.s0ge) ? '0 : hi2;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// File: rtl/core/frechet_free_space_cell_unit.sv
// Free-space cell unit: for each item of two segments it returns the free interval on the
// left edge (along the second segment, around the first start point) and on the bottom edge
// (along the first segment, around the second start point), as Q1.16 fractions rounded
// outward, with an empty flag per edge. One item is taken every cycle unless a held result stalls
// the input; its result passes through the four-stage limb multipliers and the 17-stage bit search
// over the fraction, one bit per stage. A stalled result holds the whole pipeline.
// A written range reaches the datapath through the range register, then its registered square.
// depends on ffsc_pkg, ffsc_edge
module frechet_free_space_cell_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [ffsc_pkg::CW-1:0]  req_first_start_x,
   input  logic signed [ffsc_pkg::CW-1:0]  req_first_start_y,
   input  logic signed [ffsc_pkg::CW-1:0]  req_first_end_x,
   input  logic signed [ffsc_pkg::CW-1:0]  req_first_end_y,
   input  logic signed [ffsc_pkg::CW-1:0]  req_second_start_x,
   input  logic signed [ffsc_pkg::CW-1:0]  req_second_start_y,
   input  logic signed [ffsc_pkg::CW-1:0]  req_second_end_x,
   input  logic signed [ffsc_pkg::CW-1:0]  req_second_end_y,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_left_empty,
   output logic [ffsc_pkg::FW-1:0]         rsp_left_low,
   output logic [ffsc_pkg::FW-1:0]         rsp_left_high,
   output logic                            rsp_bottom_empty,
   output logic [ffsc_pkg::FW-1:0]         rsp_bottom_low,
   output logic [ffsc_pkg::FW-1:0]         rsp_bottom_high,
   input  logic                            csr_wr_en,
   input  logic [ffsc_pkg::RW-1:0]         csr_wr_data
);
   import ffsc_pkg::*;

   logic [PIPE_DEPTH-1:0] vld_ff;
   logic                  adv;
   logic [RW-1:0]         range_ff;
   logic [RRW-1:0]        rr_ff;
   logic signed [CW-1:0]  f0x_ff, f0y_ff, f1x_ff, f1y_ff;
   logic signed [CW-1:0]  s0x_ff, s0y_ff, s1x_ff, s1y_ff;
   edge_res_type          left_res, bottom_res;

   // pipeline moves unless a finished item is held
   assign adv       = !vld_ff[PIPE_DEPTH-1] || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[PIPE_DEPTH-1];

   // range register and its square
   always_ff @(posedge clock) begin
      if (reset) begin
         range_ff <= '0;
         rr_ff    <= '0;
      end else begin
         if (csr_wr_en) begin
            range_ff <= csr_wr_data;
         end
         rr_ff <= RRW'(range_ff) * RRW'(range_ff);
      end
   end

   // item valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (adv) begin
         f0x_ff <= req_first_start_x;
         f0y_ff <= req_first_start_y;
         f1x_ff <= req_first_end_x;
         f1y_ff <= req_first_end_y;
         s0x_ff <= req_second_start_x;
         s0y_ff <= req_second_start_y;
         s1x_ff <= req_second_end_x;
         s1y_ff <= req_second_end_y;
      end
   end

   // left edge: second segment around first start
   ffsc_edge u_left (
      .clock (clock),
      .adv   (adv),
      .px    (f0x_ff),
      .py    (f0y_ff),
      .ax    (s0x_ff),
      .ay    (s0y_ff),
      .bx    (s1x_ff),
      .by    (s1y_ff),
      .rr    (rr_ff),
      .res   (left_res)
   );

   // bottom edge: first segment around second start
   ffsc_edge u_bottom (
      .clock (clock),
      .adv   (adv),
      .px    (s0x_ff),
      .py    (s0y_ff),
      .ax    (f0x_ff),
      .ay    (f0y_ff),
      .bx    (f1x_ff),
      .by    (f1y_ff),
      .rr    (rr_ff),
      .res   (bottom_res)
   );

   assign rsp_left_empty   = left_res.empty;
   assign rsp_left_low     = left_res.low;
   assign rsp_left_high    = left_res.high;
   assign rsp_bottom_empty = bottom_res.empty;
   assign rsp_bottom_low   = bottom_res.low;
   assign rsp_bottom_high  = bottom_res.high;

endmodule

// File: rtl/core/ffsc_checker.sv
// ffsc_checker: port-level checks of the free-space cell unit, bound to the top level
// depends on ffsc_pkg and frechet_free_space_cell_unit
module ffsc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_left_empty,
   input logic [ffsc_pkg::FW-1:0]         rsp_left_low,
   input logic [ffsc_pkg::FW-1:0]         rsp_left_high,
   input logic                            rsp_bottom_empty,
   input logic [ffsc_pkg::FW-1:0]         rsp_bottom_low,
   input logic [ffsc_pkg::FW-1:0]         rsp_bottom_high
);
   import ffsc_pkg::*;

   // reset empties the pipeline
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a held result keeps its item
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_left_low) &&
      $stable(rsp_left_high) && $stable(rsp_bottom_low) && $stable(rsp_bottom_high))
      else $error("held result changed");

   // input is only held back by a held result
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("input stalled with free output");

   // empty edges carry zero fractions
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_left_empty || (rsp_left_low == '0 && rsp_left_high == '0)) &&
      (!rsp_bottom_empty || (rsp_bottom_low == '0 && rsp_bottom_high == '0)))
      else $error("empty edge with nonzero interval");

   // intervals are ordered
   a_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_left_empty || rsp_left_low <= rsp_left_high) &&
      (rsp_bottom_empty || rsp_bottom_low <= rsp_bottom_high))
      else $error("interval low above high");

endmodule

bind frechet_free_space_cell_unit ffsc_checker u_ffsc_checker (.*);

// File: sim/frechet_free_space_cell_unit_test.sv
// frechet_free_space_cell_unit_test: self-checking bench for the free-space cell unit
// drives random and directed cells with idle and stall gaps, predicts both free edges exactly
// depends on ffsc_pkg and frechet_free_space_cell_unit
module frechet_free_space_cell_unit_test;
   import ffsc_pkg::*;

   typedef logic signed [CW-1:0] coord_type;
   typedef logic signed [191:0] big_type;

   typedef struct packed {
      coord_type fsx, fsy, fex, fey, ssx, ssy, sex, sey;
   } cell_type;

   typedef struct packed {
      edge_res_type left;
      edge_res_type bottom;
   } cell_res_type;

   localparam int  LAT       = 26;
   localparam int  CYCLE_MAX = 2000000;
   localparam int  ITEMS_PER_RADIUS = 140;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   cell_type      req_cell = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic          rsp_left_empty, rsp_bottom_empty;
   logic [FW-1:0] rsp_left_low, rsp_left_high, rsp_bottom_low, rsp_bottom_high;
   logic          csr_wr_en = 1'b0;
   logic [RW-1:0] csr_wr_data = '0;
   bit            quiet = 1'b0;
   longint        cycles = 0;

   // free interval arithmetic and expectation queue
   class interval_scoreboard;
      logic [RW-1:0] radius;
      cell_res_type  pending_q[$];
      int            fails;
      int            checked;

      function new();
         radius  = '0;
         fails   = 0;
         checked = 0;
      endfunction

      static function int sgn(big_type v);
         return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
      endfunction

      // signs of squared distance minus range squared, and of its slope, at fraction k
      static function void sample(big_type wx, big_type wy, big_type dx, big_type dy,
                                  big_type kr2, longint k, output int qs, output int ss);
         big_type ex, ey;
         ex = wx * 65536 + dx * big_type'(k);
         ey = wy * 65536 + dy * big_type'(k);
         qs = sgn(ex * ex + ey * ey - kr2);
         ss = sgn(ex * dx + ey * dy);
      endfunction

      function edge_res_type free_interval(coord_type px, coord_type py, coord_type ax,
                                           coord_type ay, coord_type bx, coord_type by);
         edge_res_type o;
         big_type wx, wy, dx, dy, rr, kr2;
         int      q0, s0, q1, s1, qs, ss;
         longint  lo, hi, mid;
         bit      hit;
         wx  = big_type'(ax) - big_type'(px);
         wy  = big_type'(ay) - big_type'(py);
         dx  = big_type'(bx) - big_type'(ax);
         dy  = big_type'(by) - big_type'(ay);
         rr  = big_type'({1'b0, radius}) * big_type'({1'b0, radius});
         kr2 = rr * 65536 * 65536;
         o   = '{empty: 1'b1, low: '0, high: '0};
         // zero-length segment: whole interval or nothing
         if (dx == 0 && dy == 0) begin
            if (rr - (wx * wx + wy * wy) >= 0) begin
               o.empty = 1'b0;
               o.high  = FRAC_ONE;
            end
            return o;
         end
         sample(wx, wy, dx, dy, kr2, 0, q0, s0);
         sample(wx, wy, dx, dy, kr2, 65536, q1, s1);
         hit = (q0 <= 0) || (q1 <= 0);
         // both ends outside: closest point lies inside the segment, test the line distance
         if (!hit && s0 < 0 && s1 > 0)
            hit = ((dx * dx + dy * dy) * rr - (wx * dy - wy * dx) ** 2) >= 0;
         if (!hit)
            return o;
         o.empty = 1'b0;
         // low bound: last sample still before the entry point
         if (q0 >= 0 && s0 <= 0) begin
            lo = 0;
            hi = 65537;
            while (hi - lo > 1) begin
               mid = (lo + hi) / 2;
               sample(wx, wy, dx, dy, kr2, mid, qs, ss);
               if (qs >= 0 && ss <= 0) lo = mid;
               else hi = mid;
            end
            o.low = FW'(lo);
         end
         // high bound: first sample past the exit point
         lo = -1;
         hi = 65537;
         while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            sample(wx, wy, dx, dy, kr2, mid, qs, ss);
            if (qs >= 0 && ss >= 0) hi = mid;
            else lo = mid;
         end
         if (hi > 65536) hi = 65536;
         o.high = FW'(hi);
         return o;
      endfunction

      function void note_cell(cell_type c);
         cell_res_type r;
         r.left   = free_interval(c.fsx, c.fsy, c.ssx, c.ssy, c.sex, c.sey);
         r.bottom = free_interval(c.ssx, c.ssy, c.fsx, c.fsy, c.fex, c.fey);
         pending_q.push_back(r);
      endfunction

      function void check_result(cell_res_type got);
         cell_res_type e;
         if (pending_q.size() == 0) begin
            $error("result item with no expectation waiting");
            fails++;
            return;
         end
         e = pending_q.pop_front();
         checked++;
         if (got.left.empty !== e.left.empty) begin
            $error("left_empty expected %0d got %0d", e.left.empty, got.left.empty);
            fails++;
         end
         if (got.left.low !== e.left.low) begin
            $error("left_low expected %0d got %0d", e.left.low, got.left.low);
            fails++;
         end
         if (got.left.high !== e.left.high) begin
            $error("left_high expected %0d got %0d", e.left.high, got.left.high);
            fails++;
         end
         if (got.bottom.empty !== e.bottom.empty) begin
            $error("bottom_empty expected %0d got %0d", e.bottom.empty, got.bottom.empty);
            fails++;
         end
         if (got.bottom.low !== e.bottom.low) begin
            $error("bottom_low expected %0d got %0d", e.bottom.low, got.bottom.low);
            fails++;
         end
         if (got.bottom.high !== e.bottom.high) begin
            $error("bottom_high expected %0d got %0d", e.bottom.high, got.bottom.high);
            fails++;
         end
      endfunction
   endclass

   interval_scoreboard sb = new();

   frechet_free_space_cell_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_start_x  (req_cell.fsx),
      .req_first_start_y  (req_cell.fsy),
      .req_first_end_x    (req_cell.fex),
      .req_first_end_y    (req_cell.fey),
      .req_second_start_x (req_cell.ssx),
      .req_second_start_y (req_cell.ssy),
      .req_second_end_x   (req_cell.sex),
      .req_second_end_y   (req_cell.sey),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_left_empty     (rsp_left_empty),
      .rsp_left_low       (rsp_left_low),
      .rsp_left_high      (rsp_left_high),
      .rsp_bottom_empty   (rsp_bottom_empty),
      .rsp_bottom_low     (rsp_bottom_low),
      .rsp_bottom_high    (rsp_bottom_high),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // clock and run limit
   initial begin
      forever begin
         #2 clock = ~clock;
         if (clock) begin
            cycles++;
            if (cycles > CYCLE_MAX) begin
               $display("timeout after %0d cycles", cycles);
               $display("RESULT: ERROR");
               $finish;
            end
         end
      end
   end

   // idle length: mostly short, a few long
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // result side: random stalls, check every accepted item
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result('{left: '{rsp_left_empty, rsp_left_low, rsp_left_high},
                              bottom: '{rsp_bottom_empty, rsp_bottom_low, rsp_bottom_high}});
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            hold = (pick_gap() > 0 && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
            rsp_stall <= (hold > 0);
         end
      end
   end

   // one item through the request handshake, leaving valid high
   task automatic send_cell(cell_type c);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cell  <= c;
      do @(posedge clock); while (req_stall);
      sb.note_cell(c);
   endtask

   // wait for the pipe to drain, then set the range
   task automatic write_radius(logic [RW-1:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (LAT + 4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.radius = value;
      repeat (3) @(posedge clock);
   endtask

   function automatic coord_type clamp(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return coord_type'(v);
   endfunction

   // offset drawn evenly from -span to span
   function automatic longint offset(longint span);
      return longint'($urandom_range(0, 32'(2 * span))) - span;
   endfunction

   // random cell: mostly segments clustered around the range circle
   function automatic cell_type random_cell(logic [RW-1:0] rad);
      cell_type c;
      longint   base_x, base_y, span;
      int       r;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         return c;
      end
      base_x = longint'($signed($urandom)) >>> $urandom_range(0, 12);
      base_y = longint'($signed($urandom)) >>> $urandom_range(0, 12);
      span   = (rad == 0) ? (64'sd1 << $urandom_range(0, 20))
                          : (longint'(rad) << 1) >>> $urandom_range(0, 3);
      span   = span + 1;
      // keep twice the span inside the random range
      if (span > 64'sd2147483647) span = 64'sd2147483647;
      c.fsx = clamp(base_x + offset(span));
      c.fsy = clamp(base_y + offset(span));
      c.fex = clamp(base_x + offset(span));
      c.fey = clamp(base_y + offset(span));
      c.ssx = clamp(base_x + offset(span));
      c.ssy = clamp(base_y + offset(span));
      c.sex = clamp(base_x + offset(span));
      c.sey = clamp(base_y + offset(span));
      // zero-length segments and shared points now and then
      if ($urandom_range(0, 9) == 0) {c.fex, c.fey} = {c.fsx, c.fsy};
      if ($urandom_range(0, 9) == 0) {c.sex, c.sey} = {c.ssx, c.ssy};
      if ($urandom_range(0, 15) == 0) {c.ssx, c.ssy} = {c.fsx, c.fsy};
      return c;
   endfunction

   // stimulus
   initial begin
      logic [RW-1:0] radii[6];
      localparam coord_type ONE = 32'sh10000;
      radii = '{31'h20000, 31'h0, 31'h7FFFFFFF, 31'h8000, 31'h0, 31'h640000};
      radii[4] = RW'($urandom);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (radii[p]) begin
         write_radius(radii[p]);
         if (p == 0) begin
            // range 2.0: degenerate, crossing, tangent, miss, corner and extreme cells
            send_cell('0);
            send_cell('{0, 0, 0, 0, 10 * ONE, 0, 10 * ONE, 0});
            send_cell('{0, 0, 0, 0, 2 * ONE, 0, 2 * ONE, 0});
            send_cell('{0, 0, 0, ONE, -5 * ONE, 0, 5 * ONE, 0});
            send_cell('{0, 0, 5 * ONE, 2 * ONE, -5 * ONE, 2 * ONE, 5 * ONE, 2 * ONE});
            send_cell('{0, 0, 9 * ONE, 0, -5 * ONE, 3 * ONE, 5 * ONE, 3 * ONE});
            send_cell('{0, 0, -ONE, 0, ONE, 0, 7 * ONE, 0});
            send_cell('{0, 0, ONE, ONE, 7 * ONE, 0, ONE, 0});
            send_cell('{0, 0, 2 * ONE, 0, 3 * ONE, 0, 5 * ONE, 0});
            send_cell('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                        32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000});
            send_cell('{32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                        32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
            send_cell('{-1, -1, -1, -1, -1, -1, -1, -1});
         end
         if (p == 1) begin
            // zero range: point on the segment, point at a vertex, point off the line
            send_cell('{0, 0, 4 * ONE, 0, -ONE, 0, 3 * ONE, 0});
            send_cell('{0, 0, 4 * ONE, 4 * ONE, 0, 0, 2 * ONE, 5 * ONE});
            send_cell('{0, ONE, 4 * ONE, 0, -ONE, 0, 3 * ONE, 0});
         end
         for (int i = 0; i < ITEMS_PER_RADIUS; i++) begin
            if (i % 35 == 0) quiet = ($urandom_range(0, 3) == 0);
            send_cell(random_cell(radii[p]));
         end
         quiet = 1'b0;
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (LAT + 4) @(posedge clock);
      $display("%0d cells checked over %0d range settings, including zero and full range",
               sb.checked, $size(radii));
      if (sb.fails == 0 && sb.pending_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
